@@ hw/rtl/can_signal_packer_assert.svh @@
// Assertion macros shared by the signal packer checker.
`ifndef CAN_SIGNAL_PACKER_ASSERT_SVH
`define CAN_SIGNAL_PACKER_ASSERT_SVH

// Clocked property, disabled while reset is asserted.
`define CSP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("signal packer check failed");

// Clocked property, also checked during reset.
`define CSP_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("signal packer check failed");

`endif

@@ hw/rtl/csp_pkg.sv @@
// Shared constants, types and state encoding for the CAN signal packer.
package csp_pkg;

  // Width of the frame payload and of one raw signal value.
  localparam int PayloadBits = 64;
  localparam int ValueBits   = 64;

  // Widths of the input fields.
  localparam int StartW = 6;
  localparam int LenW   = 7;
  // Walk position counter: holds start plus length, up to 127.
  localparam int PosW   = 7;
  localparam int BitPosW = 6;

  localparam logic [LenW-1:0] LenMax = LenW'(ValueBits);

  localparam logic BYTE_ORDER_MOTOROLA = 1'b0;
  localparam logic BYTE_ORDER_INTEL    = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_EMIT
  } csp_state_e;

  // One serialized bit toward the accumulator, plus the frame emit request.
  typedef struct packed {
    logic               vld;
    logic               val;
    logic [BitPosW-1:0] pos;
    logic               emit;
  } csp_wr_t;

endpackage

@@ hw/rtl/can_signal_packer.sv @@
// Top level of the CAN signal packer: serial walker feeding a payload accumulator.
// Operation: a signal's length is clamped to 64 and its bits are walked one bit per cycle;
//   a frame-closing signal then waits until the output register is free to move its payload out.
// Input: no new signal is taken while one is walked or a frame waits to move out; a zero-length
//   non-final signal is taken without a walk.
// Reset: rst_ni clears the accumulator, the walker state and the output valid at once.
module can_signal_packer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Signal input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] raw_value_i,
  input  logic [5:0]  start_bit_i,
  input  logic [6:0]  bit_length_i,
  input  logic        byte_order_i,
  input  logic        last_signal_i,
  // Frame output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] frame_payload_o
);
  import csp_pkg::*;

  // Bit stream and emit request from the walker; emit_ack closes the frame.
  csp_wr_t wr;
  logic    emit_ack;

  // Walk each accepted signal LSB first. Motorola signals count down along
  // the byte-swapped index, Intel signals count up from the start bit; drop
  // any bit that lands past the payload.
  csp_serializer u_serializer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .raw_value_i   (raw_value_i),
    .start_bit_i   (start_bit_i),
    .bit_length_i  (bit_length_i),
    .byte_order_i  (byte_order_i),
    .last_signal_i (last_signal_i),
    .wr_o          (wr),
    .emit_ack_i    (emit_ack)
  );

  // OR bits into the accumulator; on the last signal hold until the output
  // register is free, then move the frame out and clear the accumulator.
  csp_accumulator u_accumulator (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .wr_i            (wr),
    .emit_ack_o      (emit_ack),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .frame_payload_o (frame_payload_o)
  );

endmodule

@@ hw/rtl/csp_serializer.sv @@
// Bit-serial signal walker: shifts the raw value out LSB first with its payload position.
module csp_serializer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [63:0]               raw_value_i,
  input  logic [5:0]                start_bit_i,
  input  logic [6:0]                bit_length_i,
  input  logic                      byte_order_i,
  input  logic                      last_signal_i,
  output csp_pkg::csp_wr_t          wr_o,
  input  logic                      emit_ack_i
);
  import csp_pkg::*;

  csp_state_e state_q, state_d;

  logic [ValueBits-1:0] value_q, value_d;
  logic [LenW-1:0]      cnt_q, cnt_d;
  logic [PosW-1:0]      pos_q, pos_d;
  logic                 order_q, order_d;
  logic                 last_q, last_d;

  logic                 accept;
  logic [LenW-1:0]      len_eff;
  logic [StartW-1:0]    moto_lin;
  logic [PosW-1:0]      moto_end;
  logic [BitPosW-1:0]   map_pos;
  logic                 step_done;

  assign accept  = in_valid_i && in_ready_o;
  // Clamp lengths above the value width.
  assign len_eff = bit_length_i[LenW-1] ? LenMax : bit_length_i;
  // Motorola bits run along a linear index where bit 7 of a byte comes first.
  assign moto_lin = {start_bit_i[5:3], ~start_bit_i[2:0]};
  assign moto_end = PosW'({1'b0, moto_lin} + len_eff - LenW'(1));

  assign map_pos   = (order_q == BYTE_ORDER_INTEL) ? pos_q[BitPosW-1:0]
                                                   : {pos_q[5:3], ~pos_q[2:0]};
  assign step_done = (cnt_q == LenW'(1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (len_eff != '0) begin
            state_d = ST_SHIFT;
          end else if (last_signal_i) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_SHIFT: begin
        if (step_done) begin
          state_d = last_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (emit_ack_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o = 1'b0;
    wr_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_SHIFT: begin
        wr_o.vld = !pos_q[PosW-1] && ({1'b0, map_pos} < PosW'(PayloadBits));
        wr_o.val = value_q[0];
        wr_o.pos = map_pos;
      end
      ST_EMIT: begin
        wr_o.emit = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Datapath: load on accept, advance one bit per cycle while shifting.
  always_comb begin
    value_d = value_q;
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    order_d = order_q;
    last_d  = last_q;
    if (accept) begin
      value_d = raw_value_i;
      cnt_d   = len_eff;
      order_d = byte_order_i;
      last_d  = last_signal_i;
      pos_d   = (byte_order_i == BYTE_ORDER_INTEL) ? {1'b0, start_bit_i} : moto_end;
    end else if (state_q == ST_SHIFT) begin
      value_d = value_q >> 1;
      cnt_d   = cnt_q - LenW'(1);
      pos_d   = (order_q == BYTE_ORDER_INTEL) ? pos_q + PosW'(1) : pos_q - PosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    pos_q   <= pos_d;
    order_q <= order_d;
  end

endmodule

@@ hw/rtl/csp_accumulator.sv @@
// Payload accumulator and output register of the CAN signal packer.
module csp_accumulator (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  csp_pkg::csp_wr_t wr_i,
  output logic             emit_ack_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [63:0]      frame_payload_o
);
  import csp_pkg::*;

  logic [PayloadBits-1:0] acc_q, acc_d;
  logic [63:0]            out_data_q, out_data_d;
  logic                   out_valid_q, out_valid_d;

  assign emit_ack_o = wr_i.emit && (!out_valid_q || out_ready_i);

  always_comb begin
    acc_d       = acc_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (wr_i.vld && wr_i.val) begin
      acc_d[wr_i.pos] = 1'b1;
    end
    if (emit_ack_o) begin
      // Move the finished frame out and clear for the next one.
      out_data_d  = 64'(acc_q);
      out_valid_d = 1'b1;
      acc_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o     = out_valid_q;
  assign frame_payload_o = out_data_q;

endmodule

@@ hw/rtl/csp_checker.sv @@
// Port-level checker for the CAN signal packer, bound to the top level.
`include "can_signal_packer_assert.svh"

module csp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [6:0]  bit_length_i,
  input logic        last_signal_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] frame_payload_o
);

  // A pending frame holds until taken.
  `CSP_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o)
  `CSP_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i |=> $stable(frame_payload_o))
  // A signal with bits to place keeps the input stalled on the next cycle.
  `CSP_ASSERT(a_busy_walk, clk_i, rst_ni, in_valid_i && in_ready_o && (bit_length_i != 7'd0) |=> !in_ready_o)
  // An empty, non-final signal returns at once and emits nothing.
  `CSP_ASSERT(a_empty_pass, clk_i, rst_ni, in_valid_i && in_ready_o && (bit_length_i == 7'd0) && !last_signal_i |=> in_ready_o && !$rose(out_valid_o))

endmodule

bind can_signal_packer csp_checker u_csp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .bit_length_i    (bit_length_i),
  .last_signal_i   (last_signal_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .frame_payload_o (frame_payload_o)
);

@@ tb/can_signal_packer_tb.sv @@
// Self-checking testbench for can_signal_packer: Motorola and Intel placement and frame emission.
`timescale 1ns / 1ps

module can_signal_packer_tb;
  import csp_pkg::*;

  // Run length guard and the length of the forced output hold-off.
  localparam int CYCLE_LIMIT  = 600000;
  localparam int HOLD_CYCLES  = 500;
  localparam int DRAIN_CYCLES = 200;
  localparam int PHASE_ITEMS  = 225;
  localparam int MAX_SHOWN    = 10;

  // Idling modes of the sender and the receiver.
  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  // One signal as the driver presents it.
  typedef struct {
    logic [63:0] value;
    logic [5:0]  start;
    logic [6:0]  len;
    logic        order;
    logic        last;
  } signal_item_t;

  // Clock, reset and DUT pins; every input starts at a known value.
  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic [63:0] raw_value     = '0;
  logic [5:0]  start_bit     = '0;
  logic [6:0]  bit_length    = '0;
  logic        byte_order    = BYTE_ORDER_MOTOROLA;
  logic        last_signal   = 1'b0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic [63:0] frame_payload;

  // Stimulus, prediction and bookkeeping.
  signal_item_t pending_q[$];
  signal_item_t next_item;
  logic [63:0]  frame_expect_q[$];
  logic [63:0]  frame_accum = '0;
  logic [63:0]  expected_payload;
  idle_mode_e   idle_mode = IDLE_NONE;
  logic         hold_arm  = 1'b0;
  int           hold_cnt  = 0;
  int           cycle_cnt = 0;
  int           error_cnt = 0;
  int           signals_sent = 0;
  int           intel_cnt    = 0;
  int           odd_len_cnt  = 0;
  int           frames_seen  = 0;

  can_signal_packer dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .raw_value_i    (raw_value),
    .start_bit_i    (start_bit),
    .bit_length_i   (bit_length),
    .byte_order_i   (byte_order),
    .last_signal_i  (last_signal),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .frame_payload_o(frame_payload)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Place one signal at its payload positions. Oversize lengths clamp to 64,
  // a zero length adds nothing, and bits past bit 63 drop.
  function automatic logic [63:0] place_signal_bits(input logic [63:0] value,
                                                    input logic [5:0] start,
                                                    input logic [6:0] len_in,
                                                    input logic order);
    logic [63:0] bits;
    logic [63:0] keep;
    int len;
    int byte_idx;
    int bit_idx;
    int pos;
    bits = '0;
    len = (len_in > LenMax) ? 64 : int'(len_in);
    if (len == 0) return '0;
    if (order == BYTE_ORDER_INTEL) begin
      keep = (len == 64) ? '1 : ((64'd1 << len) - 64'd1);
      bits = (value & keep) << start;
    end else begin
      // Walk MSB first: down within a byte, then to bit 7 of the next byte.
      byte_idx = int'(start) >> 3;
      bit_idx  = int'(start) & 7;
      for (int k = 0; k < len; k++) begin
        pos = byte_idx * 8 + bit_idx;
        if (pos < 64) bits[pos] = value[len - 1 - k];
        if (bit_idx == 0) begin
          bit_idx = 7;
          byte_idx++;
        end else begin
          bit_idx--;
        end
      end
    end
    return bits;
  endfunction

  // Queue one signal for the driver.
  task automatic push_signal(input logic [63:0] value, input logic [5:0] start,
                             input logic [6:0] len, input logic order, input logic last);
    signal_item_t item;
    item.value = value;
    item.start = start;
    item.len   = len;
    item.order = order;
    item.last  = last;
    pending_q.push_back(item);
  endtask

  // Hold until the sender has nothing left and every frame has come back.
  task automatic wait_quiet();
    while (pending_q.size() != 0 || in_valid || frame_expect_q.size() != 0)
      @(negedge clk);
  endtask

  // Driver: predict on each accepted transaction, then present the next item
  // unless the sender idles this cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        frame_accum = frame_accum |
                      place_signal_bits(raw_value, start_bit, bit_length, byte_order);
        if (last_signal) begin
          frame_expect_q.push_back(frame_accum);
          frame_accum = '0;
        end
        signals_sent++;
        if (byte_order == BYTE_ORDER_INTEL) intel_cnt++;
        if (bit_length == 0 || bit_length > LenMax) odd_len_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (pending_q.size() != 0 &&
            !((idle_mode == IDLE_SEND && $urandom_range(99) < 62) ||
              (idle_mode == IDLE_BOTH && $urandom_range(99) < 9))) begin
          next_item   = pending_q.pop_front();
          in_valid    <= 1'b1;
          raw_value   <= next_item.value;
          start_bit   <= next_item.start;
          bit_length  <= next_item.len;
          byte_order  <= next_item.order;
          last_signal <= next_item.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long output hold-off, counted here so the sender keeps offering meanwhile.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt <= 0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_arm) begin
      hold_cnt <= HOLD_CYCLES;
    end
  end

  // Monitor: compare each accepted frame with the oldest expectation, then
  // pick the ready level for the next cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        frames_seen++;
        if (frame_expect_q.size() == 0) begin
          error_cnt++;
          if (error_cnt <= MAX_SHOWN)
            $display("unexpected frame: actual %016h", frame_payload);
        end else begin
          expected_payload = frame_expect_q.pop_front();
          if (frame_payload !== expected_payload) begin
            error_cnt++;
            if (error_cnt <= MAX_SHOWN)
              $display("frame_payload mismatch: expected %016h actual %016h",
                       expected_payload, frame_payload);
          end
        end
      end
      if (hold_cnt != 0)
        out_ready <= 1'b0;
      else if (idle_mode == IDLE_RECV)
        out_ready <= ($urandom_range(99) >= 62);
      else if (idle_mode == IDLE_BOTH)
        out_ready <= ($urandom_range(99) >= 9);
      else
        out_ready <= 1'b1;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("can_signal_packer_tb: errors");
      $finish;
    end
  end

  // Stimulus: directed frames, then one random phase per idling mode.
  initial begin
    int count;
    int n;
    int r;
    logic [63:0] v;
    logic [6:0]  len;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Full-width signals in both orders.
    push_signal('1, 6'd0, 7'd64, BYTE_ORDER_INTEL, 1'b1);
    push_signal(64'h0123_4567_89AB_CDEF, 6'd7, 7'd64, BYTE_ORDER_MOTOROLA, 1'b1);
    push_signal('0, 6'd63, 7'd64, BYTE_ORDER_MOTOROLA, 1'b1);
    // Zero length adds nothing but still emits.
    push_signal('1, 6'd12, 7'd0, BYTE_ORDER_INTEL, 1'b1);
    push_signal('1, 6'd40, 7'd0, BYTE_ORDER_MOTOROLA, 1'b1);
    // Lengths above 64 clamp.
    push_signal(64'hFEDC_BA98_7654_3210, 6'd0, 7'd127, BYTE_ORDER_INTEL, 1'b1);
    push_signal(64'hA5A5_5A5A_0F0F_F0F0, 6'd7, 7'd100, BYTE_ORDER_MOTOROLA, 1'b1);
    // Bits beyond the payload drop.
    push_signal('1, 6'd63, 7'd64, BYTE_ORDER_INTEL, 1'b1);
    push_signal('1, 6'd56, 7'd16, BYTE_ORDER_MOTOROLA, 1'b0);
    push_signal(64'h0000_0000_0000_ABCD, 6'd0, 7'd16, BYTE_ORDER_MOTOROLA, 1'b1);
    // Intel masking: upper value bits must not leak.
    push_signal('1, 6'd0, 7'd1, BYTE_ORDER_INTEL, 1'b0);
    push_signal('1, 6'd60, 7'd8, BYTE_ORDER_INTEL, 1'b0);
    push_signal('0, 6'd3, 7'd1, BYTE_ORDER_MOTOROLA, 1'b1);
    // A frame built up over several signals, overlapping ones included.
    push_signal(64'h5, 6'd4, 7'd3, BYTE_ORDER_INTEL, 1'b0);
    push_signal(64'h3C, 6'd15, 7'd6, BYTE_ORDER_MOTOROLA, 1'b0);
    push_signal(64'h8000_0000_0000_0000, 6'd32, 7'd64, BYTE_ORDER_INTEL, 1'b0);
    push_signal(64'h1FF, 6'd33, 7'd9, BYTE_ORDER_MOTOROLA, 1'b0);
    push_signal(64'hFF, 6'd20, 7'd4, BYTE_ORDER_INTEL, 1'b1);
    push_signal(64'h1, 6'd0, 7'd1, BYTE_ORDER_MOTOROLA, 1'b1);
    wait_quiet();

    for (int phase = 0; phase < 4; phase++) begin
      idle_mode <= idle_mode_e'(phase);
      // Freeze the receiver early in the first phase while items keep coming.
      if (phase == 0) begin
        @(posedge clk);
        hold_arm <= 1'b1;
        @(posedge clk);
        hold_arm <= 1'b0;
        @(negedge clk);
      end
      count = 0;
      while (count < PHASE_ITEMS) begin
        n = $urandom_range(6, 1);
        for (int k = 0; k < n; k++) begin
          r = $urandom_range(99);
          if (r < 4)       len = 7'd0;
          else if (r < 8)  len = 7'($urandom_range(127, 65));
          else if (r < 25) len = 7'($urandom_range(8, 1));
          else             len = 7'($urandom_range(64, 1));
          r = $urandom_range(9);
          if (r == 0)      v = '0;
          else if (r == 1) v = '1;
          else if (r == 2) v = 64'd1 << $urandom_range(63);
          else             v = {$urandom, $urandom};
          push_signal(v, 6'($urandom_range(63)), len, 1'($urandom_range(1)), k == n - 1);
        end
        count += n;
      end
      // Pause the sender until every frame of the phase has come back.
      wait_quiet();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("summary: %0d signals (%0d Intel, %0d zero or oversize length), %0d frames",
             signals_sent, intel_cnt, odd_len_cnt, frames_seen);
    $display("summary: no idling, sender gaps, receiver stalls, both, %0d-cycle hold-off",
             HOLD_CYCLES);
    if (error_cnt > MAX_SHOWN)
      $display("%0d further mismatches not shown", error_cnt - MAX_SHOWN);
    if (error_cnt == 0 && frame_expect_q.size() == 0) begin
      $display("can_signal_packer_tb: clean");
    end else begin
      $display("can_signal_packer_tb: errors");
    end
    $finish;
  end

endmodule
